// ----- sv/ffrp_pkg.sv -----
// Shared types, codes and helper functions of the first-fit resource placer.
package ffrp_pkg;

    // Field widths fixed by the request and result formats.
    localparam int AMT_W  = 16;
    localparam int TIME_W = 24;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 4;
    localparam int OUT_W  = 2;
    localparam int CFG_W  = 5;

    // Largest representable time value.
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Reset value of the scanned-node count register.
    localparam logic [CFG_W-1:0] NODES_IN_USE_RST = 5'd16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SET_CAP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_DIST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLACE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd3;

    // Outcome codes.
    localparam logic [OUT_W-1:0] OUT_OK       = 2'd0;
    localparam logic [OUT_W-1:0] OUT_NO_FIT   = 2'd1;
    localparam logic [OUT_W-1:0] OUT_DEADLINE = 2'd2;

    // One node's capacities and current loads.
    typedef struct packed {
        logic [AMT_W-1:0] cap_cpu;
        logic [AMT_W-1:0] cap_mem;
        logic [AMT_W-1:0] cap_dsk;
        logic [AMT_W-1:0] load_cpu;
        logic [AMT_W-1:0] load_mem;
        logic [AMT_W-1:0] load_dsk;
    } t_node_rec;

    // True when the free amount (zero if the load exceeds the capacity) covers the need.
    function automatic logic fits_one(input logic [AMT_W-1:0] cap,
                                      input logic [AMT_W-1:0] load,
                                      input logic [AMT_W-1:0] need);
        logic [AMT_W:0] total;
        total = {1'b0, load} + {1'b0, need};
        return ({1'b0, cap} >= total) || (need == '0);
    endfunction

    // Load decreased by an amount, held at zero.
    function automatic logic [AMT_W-1:0] sub_sat(input logic [AMT_W-1:0] load,
                                                 input logic [AMT_W-1:0] amt);
        return (amt >= load) ? '0 : (load - amt);
    endfunction

endpackage

// ----- sv/first_fit_resource_placer_unit.sv -----
// First-fit placer of subtasks on a table of nodes with CPU, memory and disk resources.
//
// Each request takes one command and returns one result. Setting a capacity or a
// distance goes from acceptance straight to the result state and into the output
// register, and the block then returns to idle for the next request. A release reads
// the node record from the node memory before writing it back. A placement scans the
// nodes one per cycle through the single read port of the node memory, stopping at
// the first node that fits. The tail of a placement is the distance memory read, the
// three-stage constant divider and the deadline check. A result that finds the output
// register still held waits there, and the block stays busy until the result moves.
// After reset the block sweeps both memories to zero, one entry a cycle, over
// 2**(2*clog2(NODE_COUNT)) addresses (256 with sixteen nodes) before it takes its
// first request; the node count register may be written at any time meanwhile.
module first_fit_resource_placer_unit #(
    parameter int NODE_COUNT    = 16,
    parameter int DELAY_DIVISOR = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ffrp_pkg::CFG_W-1:0]   i_cfg_data,
    // Request channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ffrp_pkg::CMD_W-1:0]   i_command,
    input  logic [ffrp_pkg::IDX_W-1:0]   i_node_index,
    input  logic [ffrp_pkg::IDX_W-1:0]   i_other_node_index,
    input  logic [ffrp_pkg::AMT_W-1:0]   i_cpu_amount,
    input  logic [ffrp_pkg::AMT_W-1:0]   i_memory_amount,
    input  logic [ffrp_pkg::AMT_W-1:0]   i_disk_amount,
    input  logic [ffrp_pkg::AMT_W-1:0]   i_distance_value,
    input  logic                         i_first_of_task,
    input  logic [ffrp_pkg::TIME_W-1:0]  i_arrive_time,
    input  logic [ffrp_pkg::AMT_W-1:0]   i_run_duration,
    input  logic [ffrp_pkg::TIME_W-1:0]  i_deadline_time,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ffrp_pkg::OUT_W-1:0]   o_outcome,
    output logic [ffrp_pkg::IDX_W-1:0]   o_host_node,
    output logic [ffrp_pkg::TIME_W-1:0]  o_start_time
);

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int ND    = 1 << NW;
    localparam int DAW   = 2 * NW;
    localparam int DD    = 1 << DAW;
    localparam int CW    = $clog2(NODE_COUNT + 1);
    localparam int AW    = ffrp_pkg::AMT_W;
    localparam int TW    = ffrp_pkg::TIME_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REL    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRD    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DWAIT  = 3'd5;
    localparam logic [2:0] S_END    = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    // Memories.
    ffrp_pkg::t_node_rec r_node_mem [ND];
    logic [AW-1:0]       r_dist_mem [DD];
    ffrp_pkg::t_node_rec r_node_rd;
    logic [AW-1:0]       r_dist_rd;

    // Control state.
    logic [2:0]                 r_state, n_state;
    logic                       r_clr_busy;
    logic [DAW-1:0]             r_clr_addr;
    logic [ffrp_pkg::CFG_W-1:0] r_nodes_in_use;
    logic [CW-1:0]              r_j, n_j;
    logic                       r_live, n_live;
    logic [NW-1:0]              r_live_idx, n_live_idx;
    logic                       r_out_valid;
    logic [NW-1:0]              r_prev_node;
    logic [TW-1:0]              r_prev_end;

    // Payload of the request in progress.
    logic [NW-1:0]              r_node;
    logic                       r_node_ok;
    logic [AW-1:0]              r_cpu, r_mem, r_dsk;
    logic                       r_first;
    logic [TW-1:0]              r_arrive;
    logic [AW-1:0]              r_dur;
    logic [TW-1:0]              r_deadline;
    logic [NW-1:0]              r_host;
    ffrp_pkg::t_node_rec        r_rec;
    logic [TW-1:0]              r_start;
    logic [ffrp_pkg::OUT_W-1:0] r_res_outcome;
    logic [ffrp_pkg::IDX_W-1:0] r_res_host;
    logic [TW-1:0]              r_res_start;
    logic [ffrp_pkg::OUT_W-1:0] r_out_outcome;
    logic [ffrp_pkg::IDX_W-1:0] r_out_host;
    logic [TW-1:0]              r_out_start;

    // Combinational helpers.
    logic                       w_accept;
    logic                       w_in_node_ok;
    logic                       w_in_other_ok;
    logic [CW-1:0]              w_count;
    logic                       w_fits;
    logic                       w_found;
    logic                       w_no_fit;
    logic [NW-1:0]              w_node_raddr;
    logic                       w_node_we;
    logic [NW-1:0]              w_node_waddr;
    ffrp_pkg::t_node_rec        w_node_wdata;
    logic                       w_dist_we;
    logic [DAW-1:0]             w_dist_waddr;
    logic [AW-1:0]              w_dist_wdata;
    logic [DAW-1:0]             w_dist_raddr;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [AW-1:0]              w_quot;
    logic [TW:0]                w_delay_sum;
    logic [TW:0]                w_end_sum;
    logic [TW-1:0]              w_end_sat;
    logic                       w_late;
    logic                       w_res_load;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE) && !r_clr_busy;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_in_node_ok  = 32'(i_node_index) < 32'(NODE_COUNT);
    assign w_in_other_ok = 32'(i_other_node_index) < 32'(NODE_COUNT);

    // Number of nodes a placement scans.
    always_comb begin
        if (32'(r_nodes_in_use) > 32'(NODE_COUNT)) begin
            w_count = CW'(NODE_COUNT);
        end else begin
            w_count = CW'(r_nodes_in_use);
        end
    end

    // Fit check of the node record read in the previous cycle.
    assign w_fits = ffrp_pkg::fits_one(r_node_rd.cap_cpu, r_node_rd.load_cpu, r_cpu) &&
                    ffrp_pkg::fits_one(r_node_rd.cap_mem, r_node_rd.load_mem, r_mem) &&
                    ffrp_pkg::fits_one(r_node_rd.cap_dsk, r_node_rd.load_dsk, r_dsk);
    assign w_found  = (r_state == S_SCAN) && r_live && w_fits;
    assign w_no_fit = (r_state == S_SCAN) && !w_found && !(r_j < w_count);

    // Start time of a later subtask and end time of the placed one, both saturating.
    assign w_delay_sum = {1'b0, r_prev_end} + (TW + 1)'(w_quot);
    assign w_end_sum   = {1'b0, r_start} + (TW + 1)'(r_dur);
    assign w_end_sat   = w_end_sum[TW] ? ffrp_pkg::TIME_MAX : w_end_sum[TW-1:0];
    assign w_late      = w_end_sum > {1'b0, r_deadline};

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_live     = r_live;
        n_live_idx = r_live_idx;
        case (r_state)
            S_IDLE: begin
                n_j    = '0;
                n_live = 1'b0;
                if (w_accept) begin
                    case (i_command)
                        ffrp_pkg::CMD_PLACE:   n_state = S_SCAN;
                        ffrp_pkg::CMD_RELEASE: n_state = S_REL;
                        default:               n_state = S_RESULT;
                    endcase
                end
            end
            S_REL: begin
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if (w_found) begin
                    n_state = S_DRD;
                    n_live  = 1'b0;
                end else if (r_j < w_count) begin
                    n_j        = r_j + CW'(1);
                    n_live     = 1'b1;
                    n_live_idx = r_j[NW-1:0];
                end else begin
                    n_state = S_RESULT;
                    n_live  = 1'b0;
                end
            end
            S_DRD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_j        <= '0;
            r_live     <= 1'b0;
            r_live_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_j        <= n_j;
            r_live     <= n_live;
            r_live_idx <= n_live_idx;
        end
    end

    // Clearing sweep over both memories after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + DAW'(1);
            if (r_clr_addr == {DAW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Node count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_in_use <= ffrp_pkg::NODES_IN_USE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_nodes_in_use <= i_cfg_data;
        end
    end

    // Capture of the request payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_node     <= NW'(i_node_index);
            r_node_ok  <= w_in_node_ok;
            r_cpu      <= i_cpu_amount;
            r_mem      <= i_memory_amount;
            r_dsk      <= i_disk_amount;
            r_first    <= i_first_of_task;
            r_arrive   <= i_arrive_time;
            r_dur      <= i_run_duration;
            r_deadline <= i_deadline_time;
        end
    end

    // Node memory read address: the release target or the next node of the scan.
    assign w_node_raddr = (r_state == S_SCAN) ? r_j[NW-1:0] : NW'(i_node_index);

    // Node memory write port.
    always_comb begin
        w_node_we    = 1'b0;
        w_node_waddr = r_node;
        w_node_wdata = r_node_rd;
        if (r_clr_busy) begin
            w_node_we    = 1'b1;
            w_node_waddr = r_clr_addr[NW-1:0];
            w_node_wdata = '0;
        end else if (w_accept && (i_command == ffrp_pkg::CMD_SET_CAP) && w_in_node_ok) begin
            // A new capacity also clears the node's load.
            w_node_we            = 1'b1;
            w_node_waddr         = NW'(i_node_index);
            w_node_wdata         = '0;
            w_node_wdata.cap_cpu = i_cpu_amount;
            w_node_wdata.cap_mem = i_memory_amount;
            w_node_wdata.cap_dsk = i_disk_amount;
        end else if ((r_state == S_REL) && r_node_ok) begin
            w_node_we              = 1'b1;
            w_node_waddr           = r_node;
            w_node_wdata           = r_node_rd;
            w_node_wdata.load_cpu  = ffrp_pkg::sub_sat(r_node_rd.load_cpu, r_cpu);
            w_node_wdata.load_mem  = ffrp_pkg::sub_sat(r_node_rd.load_mem, r_mem);
            w_node_wdata.load_dsk  = ffrp_pkg::sub_sat(r_node_rd.load_dsk, r_dsk);
        end else if ((r_state == S_END) && !w_late) begin
            // Commit the placed subtask's load on the chosen node.
            w_node_we             = 1'b1;
            w_node_waddr          = r_host;
            w_node_wdata          = r_rec;
            w_node_wdata.load_cpu = r_rec.load_cpu + r_cpu;
            w_node_wdata.load_mem = r_rec.load_mem + r_mem;
            w_node_wdata.load_dsk = r_rec.load_dsk + r_dsk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_waddr] <= w_node_wdata;
        end
        r_node_rd <= r_node_mem[w_node_raddr];
    end

    // Distance memory: rows by chosen node, columns by previous node.
    always_comb begin
        w_dist_we    = 1'b0;
        w_dist_waddr = {NW'(i_node_index), NW'(i_other_node_index)};
        w_dist_wdata = i_distance_value;
        if (r_clr_busy) begin
            w_dist_we    = 1'b1;
            w_dist_waddr = r_clr_addr;
            w_dist_wdata = '0;
        end else if (w_accept && (i_command == ffrp_pkg::CMD_SET_DIST) &&
                     w_in_node_ok && w_in_other_ok) begin
            w_dist_we = 1'b1;
        end
    end

    assign w_dist_raddr = {r_host, r_prev_node};

    always_ff @(posedge i_clk) begin
        if (w_dist_we) begin
            r_dist_mem[w_dist_waddr] <= w_dist_wdata;
        end
        r_dist_rd <= r_dist_mem[w_dist_raddr];
    end

    // Chosen node and its record, held for the rest of the placement.
    always_ff @(posedge i_clk) begin
        if (w_found) begin
            r_host <= r_live_idx;
            r_rec  <= r_node_rd;
        end
    end

    // Transfer delay: distance divided by the fixed divisor.
    assign w_div_start = (r_state == S_DIV);

    ffrp_delay_div #(
        .DIVISOR (DELAY_DIVISOR)
    ) u_delay_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_dist_rd),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Start time: the arrival for a first subtask, else previous end plus delay.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DWAIT) && w_div_done) begin
            if (r_first) begin
                r_start <= r_arrive;
            end else begin
                r_start <= w_delay_sum[TW] ? ffrp_pkg::TIME_MAX : w_delay_sum[TW-1:0];
            end
        end
    end

    // Previous placement, updated only on success.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_node <= '0;
            r_prev_end  <= '0;
        end else if ((r_state == S_END) && !w_late) begin
            r_prev_node <= r_host;
            r_prev_end  <= w_end_sat;
        end
    end

    // Result of the request in progress.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_outcome <= ffrp_pkg::OUT_OK;
            r_res_host    <= '0;
            r_res_start   <= '0;
        end else if (w_no_fit) begin
            r_res_outcome <= ffrp_pkg::OUT_NO_FIT;
        end else if (r_state == S_END) begin
            r_res_outcome <= w_late ? ffrp_pkg::OUT_DEADLINE : ffrp_pkg::OUT_OK;
            r_res_host    <= ffrp_pkg::IDX_W'(r_host);
            r_res_start   <= r_start;
        end
    end

    // Output register: the result moves there once the previous one has been taken.
    assign w_res_load = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_outcome <= r_res_outcome;
            r_out_host    <= r_res_host;
            r_out_start   <= r_res_start;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_outcome    = r_out_outcome;
    assign o_host_node  = r_out_host;
    assign o_start_time = r_out_start;

endmodule

// ----- sv/ffrp_delay_div.sv -----
// Divides a distance by a fixed constant with a reciprocal multiply and one correction step.
module ffrp_delay_div #(
    parameter int DIVISOR = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ffrp_pkg::AMT_W-1:0]  i_dividend,
    output logic                        o_done,
    output logic [ffrp_pkg::AMT_W-1:0]  o_quotient
);

    localparam int AW     = ffrp_pkg::AMT_W;
    localparam int SHIFT  = 32;
    localparam int MW     = SHIFT + 1;
    localparam int DW     = $clog2(DIVISOR + 1);
    localparam int PW     = AW + MW;
    localparam int QDW    = AW + DW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SHIFT) / DIVISOR);
    localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);

    logic [PW-1:0]  r_prod;
    logic [AW-1:0]  r_x1;
    logic [AW-1:0]  r_x2;
    logic [AW-1:0]  r_q_est;
    logic [2:0]     r_stage;
    logic [AW-1:0]  r_quot;
    logic [QDW-1:0] w_back;
    logic [QDW-1:0] w_rem;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
        end
    end

    // Stage one: multiply by the scaled reciprocal.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(i_dividend) * PW'(RECIP);
            r_x1   <= i_dividend;
        end
    end

    // Stage two: the estimate is the true quotient or one below it.
    always_ff @(posedge i_clk) begin
        if (r_stage[0]) begin
            r_q_est <= r_prod[SHIFT +: AW];
            r_x2    <= r_x1;
        end
    end

    // Stage three: the remainder tells whether the estimate needs one more.
    assign w_back = QDW'(r_q_est) * QDW'(DIV_C);
    assign w_rem  = QDW'(r_x2) - w_back;

    always_ff @(posedge i_clk) begin
        if (r_stage[1]) begin
            r_quot <= (w_rem >= QDW'(DIV_C)) ? (r_q_est + AW'(1)) : r_q_est;
        end
    end

    assign o_done     = r_stage[2];
    assign o_quotient = r_quot;

endmodule
